/* design/jaccard_distance_unit_core_macros.svh */
// ----------------------------------------------------------------------------
// jaccard distance unit assertion macros
// shared concurrent assertion wrappers, clocked on clk with arst_n as disable
// ----------------------------------------------------------------------------
`ifndef JACCARD_DISTANCE_UNIT_CORE_MACROS_SVH
`define JACCARD_DISTANCE_UNIT_CORE_MACROS_SVH

// same-cycle implication
`define JDU_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define JDU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/jdu_pkg.sv */
// ----------------------------------------------------------------------------
// jdu_pkg
// widths, constants and controller-to-datapath types of the jaccard unit
// ----------------------------------------------------------------------------
`default_nettype none

package jdu_pkg;

	localparam int ELEM_W     = 16;
	localparam int MAX_LENGTH = 4096;
	localparam int CNT_W      = 13;
	localparam int FRAC_BITS  = 16;
	localparam int DIST_W     = FRAC_BITS + 1;
	localparam int DIV_STEPS  = DIST_W;
	localparam int STEP_W     = $clog2(DIV_STEPS);
	localparam int IN_DATA_W  = 2 * ELEM_W;
	localparam int OUT_DATA_W = 48;
	localparam int OUT_USED_W = DIST_W + 2 * CNT_W;

	// commands from the controller to the datapath
	typedef struct packed {
		logic accept;    // element beat taken this cycle
		logic last;      // that beat closes the vector pair
		logic div_step;  // one quotient bit
		logic load_out;  // move result into output registers
	} jdu_cmd_t;

	typedef enum logic [2:0] {
		ST_ACCUM  = 3'b001,
		ST_DIVIDE = 3'b010,
		ST_EMIT   = 3'b100
	} jdu_state_t;

endpackage

`default_nettype wire

/* design/jdu_ctrl.sv */
// ----------------------------------------------------------------------------
// jdu_ctrl
// sequencer: accumulate, divide bit-serially, hand over the result
// ----------------------------------------------------------------------------
`default_nettype none

module jdu_ctrl
	import jdu_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  wire logic     in_last,
	output logic          in_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	output jdu_cmd_t      cmd
);

	jdu_state_t        state_q;
	jdu_state_t        state_d;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic              out_free;

	assign in_ready  = (state_q == ST_ACCUM);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		state_d      = state_q;
		cmd.accept   = 1'b0;
		cmd.last     = 1'b0;
		cmd.div_step = 1'b0;
		cmd.load_out = 1'b0;
		case (state_q)
			ST_ACCUM: begin
				cmd.accept = in_valid;
				cmd.last   = in_valid && in_last;
				if (in_valid && in_last) begin
					state_d = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				cmd.div_step = 1'b1;
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_ACCUM;
				end
			end
			default: begin
				state_d = ST_ACCUM;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_ACCUM;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DIVIDE) begin
				step_q <= step_q + 1'b1;
			end else begin
				step_q <= '0;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

/* design/jdu_dpath.sv */
// ----------------------------------------------------------------------------
// jdu_dpath
// saturating counters, restoring divider and output registers
// ----------------------------------------------------------------------------
`default_nettype none

module jdu_dpath
	import jdu_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire jdu_cmd_t          cmd,
	input  wire logic [ELEM_W-1:0] a_value,
	input  wire logic [ELEM_W-1:0] b_value,
	output logic [DIST_W-1:0]      distance_fraction,
	output logic [CNT_W-1:0]       differ_count,
	output logic [CNT_W-1:0]       union_count,
	output logic                   undefined_result
);

	logic [CNT_W-1:0]  differ_acc_q;
	logic [CNT_W-1:0]  union_acc_q;
	logic [CNT_W-1:0]  differ_nxt;
	logic [CNT_W-1:0]  union_nxt;
	logic [CNT_W-1:0]  differ_cap_q;
	logic [CNT_W-1:0]  union_cap_q;
	logic [CNT_W-1:0]  rem_q;
	logic [DIST_W-1:0] quo_q;
	logic              rem_ge;
	logic [CNT_W-1:0]  rem_sub;
	logic [CNT_W-1:0]  rem_kept;

	// counts saturate at MAX_LENGTH
	always_comb begin
		differ_nxt = differ_acc_q;
		union_nxt  = union_acc_q;
		if (a_value != b_value) begin
			differ_nxt = (differ_acc_q >= CNT_W'(MAX_LENGTH)) ?
				CNT_W'(MAX_LENGTH) : differ_acc_q + 1'b1;
		end
		if ((a_value != '0) || (b_value != '0)) begin
			union_nxt = (union_acc_q >= CNT_W'(MAX_LENGTH)) ?
				CNT_W'(MAX_LENGTH) : union_acc_q + 1'b1;
		end
	end

	// one restoring step; remainder stays below 2*union so fits CNT_W
	assign rem_ge   = (rem_q >= union_cap_q);
	assign rem_sub  = rem_q - union_cap_q;
	assign rem_kept = rem_ge ? rem_sub : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			differ_acc_q <= '0;
			union_acc_q  <= '0;
		end else if (cmd.accept) begin
			if (cmd.last) begin
				differ_acc_q <= '0;
				union_acc_q  <= '0;
			end else begin
				differ_acc_q <= differ_nxt;
				union_acc_q  <= union_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && cmd.last) begin
			differ_cap_q <= differ_nxt;
			union_cap_q  <= union_nxt;
			rem_q        <= differ_nxt;
			quo_q        <= '0;
		end else if (cmd.div_step) begin
			rem_q <= {rem_kept[CNT_W-2:0], 1'b0};
			quo_q <= {quo_q[DIST_W-2:0], rem_ge};
		end
		if (cmd.load_out) begin
			distance_fraction <= (union_cap_q == '0) ? '0 : quo_q;
			differ_count      <= differ_cap_q;
			union_count       <= union_cap_q;
			undefined_result  <= (union_cap_q == '0);
		end
	end

endmodule

`default_nettype wire

/* design/jaccard_distance_unit_core.sv */
// ----------------------------------------------------------------------------
// jaccard_distance_unit_core
// streaming jaccard distance: differ count over union count, 16 fraction bits
// ----------------------------------------------------------------------------
//  channel  dir  beat contents
//  s_axis   in   tdata {b_value, a_value}, tlast last_element
//  m_axis   out  tdata {union, differ, distance}, tuser undefined_result
//
//  one element pair is taken per cycle while a vector pair is being counted
//  the beat with tlast starts a bit-serial division, then the emit state
//  loads the result; no new pair is taken until the emit is done
//  the result waits in an output register; counting of the next pair can
//  start while it is not yet taken, a second result stalls in emit
//  arst_n clears counters, sequencer and output valid
// ----------------------------------------------------------------------------
`default_nettype none

`include "jaccard_distance_unit_core_macros.svh"

module jaccard_distance_unit_core
	import jdu_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// slave side
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,   // a_value[15:0], b_value[31:16]
	input  wire logic                  s_tlast,   // last_element
	// master side
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata,   // distance_fraction[16:0],
	                                              // differ_count[29:17],
	                                              // union_count[42:30], zero pad
	output logic                       m_tuser    // undefined_result
);

	jdu_cmd_t          cmd;
	logic [DIST_W-1:0] distance_fraction;
	logic [CNT_W-1:0]  differ_count;
	logic [CNT_W-1:0]  union_count;

	// sequencer owns both handshakes
	jdu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_last   (s_tlast),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd)
	);

	// counting, division and result registers
	jdu_dpath u_dpath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.a_value           (s_tdata[ELEM_W-1:0]),
		.b_value           (s_tdata[IN_DATA_W-1:ELEM_W]),
		.distance_fraction (distance_fraction),
		.differ_count      (differ_count),
		.union_count       (union_count),
		.undefined_result  (m_tuser)
	);

	assign m_tdata = {{(OUT_DATA_W - OUT_USED_W){1'b0}},
		union_count, differ_count, distance_fraction};

	// undefined flag tracks an empty union
	`JDU_ASSERT_SAME(a_undef_union, m_tvalid, m_tuser == (union_count == '0), "undefined flag mismatch")
	// a differing position is always in the union
	`JDU_ASSERT_SAME(a_differ_le_union, m_tvalid, differ_count <= union_count, "differ above union")
	// fraction never exceeds one
	`JDU_ASSERT_SAME(a_frac_range, m_tvalid, distance_fraction <= DIST_W'(1 << FRAC_BITS), "fraction above one")
	// the closing beat stops input for the division
	`JDU_ASSERT_NEXT(a_stop_after_last, s_tvalid && s_tready && s_tlast, !s_tready, "input open during divide")

endmodule

`default_nettype wire
